// ===== hdl/gds_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gds_pkg
// Types, constants, microcode table and calendar helpers for the day stepper.
// ---------------------------------------------------------------------------
package gds_pkg;

    // Field widths on the stream ports
    localparam int DAY_COUNT_W = 16;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // Operation codes
    localparam logic [1:0] OP_FWD  = 2'd0;
    localparam logic [1:0] OP_BACK = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Date after reset
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 16'd1950;
    localparam logic               RST_LEAP  = 1'b0;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAYS_DEC  = 5'd31;

    // year / 25 for any 16-bit year: (year * RECIP) >> SHIFT
    localparam logic [16:0] DIV25_RECIP = 17'd83887;
    localparam int          DIV25_SHIFT = 21;
    localparam int          Q25_W       = 12;

    // Micro-actions driving the datapath
    typedef enum logic [2:0] {
        A_NONE,
        A_ACCEPT,
        A_STEP,
        A_LEAP_MUL,
        A_LEAP_SET,
        A_CHECK,
        A_LOAD,
        A_EMIT
    } t_act;

    // Jump conditions; jump taken when true, else fall through
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_LOAD,
        C_STEP_CONT,
        C_NO_YCHG,
        C_LD_BAD,
        C_OUT_BUSY
    } t_cond;

    typedef logic [3:0] t_upc;

    localparam t_upc P_EMIT  = 4'd0;
    localparam t_upc P_IDLE  = 4'd1;
    localparam t_upc P_DISP  = 4'd2;
    localparam t_upc P_LOOP  = 4'd3;
    localparam t_upc P_YCHK  = 4'd4;
    localparam t_upc P_LEAPA = 4'd5;
    localparam t_upc P_LEAPB = 4'd6;
    localparam t_upc P_LDCHK = 4'd7;
    localparam t_upc P_LOAD  = 4'd8;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Control store
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            P_EMIT:  w = '{act: A_EMIT,     cond: C_OUT_BUSY,  target: P_EMIT};
            P_IDLE:  w = '{act: A_ACCEPT,   cond: C_NO_INPUT,  target: P_IDLE};
            P_DISP:  w = '{act: A_NONE,     cond: C_IS_LOAD,   target: P_LDCHK};
            P_LOOP:  w = '{act: A_STEP,     cond: C_STEP_CONT, target: P_LOOP};
            P_YCHK:  w = '{act: A_NONE,     cond: C_NO_YCHG,   target: P_EMIT};
            P_LEAPA: w = '{act: A_LEAP_MUL, cond: C_NEVER,     target: P_IDLE};
            P_LEAPB: w = '{act: A_LEAP_SET, cond: C_ALWAYS,    target: P_LOOP};
            P_LDCHK: w = '{act: A_CHECK,    cond: C_LD_BAD,    target: P_EMIT};
            P_LOAD:  w = '{act: A_LOAD,     cond: C_ALWAYS,    target: P_LEAPA};
            default: w = '{act: A_NONE,     cond: C_ALWAYS,    target: P_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] d;
        case (month) inside
            MONTH_FEB:                  d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/gregorian_day_stepper_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_day_stepper_top
// Gregorian date register stepped by a microcoded day-at-a-time sequencer.
// ---------------------------------------------------------------------------
// Each request loads a date (op 2), advances it (op 0) or moves it back
// (op 1) by day_count days, and returns one result with the date afterward.
// Stepping runs one day per clock in the step loop of the control program,
// which it leaves at every year boundary crossed to recompute the leap flag
// through the divide-by-25 multiplier. A load also recomputes the leap flag;
// a rejected load and op 3 leave the date as it is. The next request is
// taken while the previous result still waits in the output register.
// ---------------------------------------------------------------------------
module gregorian_day_stepper_top
    import gds_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op[1:0], day_count[17:2], load_day[22:18], load_month[26:23],
    // load_year[42:27], zero fill[47:43]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cur_day[4:0], cur_month[8:5], cur_year[24:9], load_rejected[25],
    // zero fill[31:26]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CntW = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;

    t_uword uw;

    t_upc                r_upc, n_upc;
    logic [1:0]          r_op, n_op;
    logic [CntW-1:0]     r_steps, n_steps;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic                r_leap, n_leap;
    logic [Q25_W-1:0]    r_q25, n_q25;
    logic                r_ychg, n_ychg;
    logic                r_rej, n_rej;
    logic [DAY_W-1:0]    r_ld_day, n_ld_day;
    logic [MONTH_W-1:0]  r_ld_month, n_ld_month;
    logic [YEAR_W-1:0]   r_ld_year, n_ld_year;
    logic                r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [1:0]          in_op;
    logic [DAY_W-1:0]    dim, dim_prev;
    logic [DAY_W:0]      day_inc;
    logic                fwd_roll, fwd_ywrap, back_roll, back_ywrap;
    logic                ychg_now, steps_nz, ld_bad, out_busy, take;
    logic [32:0]         q25_prod;
    logic [16:0]         q25_x25;
    logic                div25;

    assign uw    = ucode_rom(r_upc);
    assign in_op = s_axis_tdata[1:0];

    assign dim        = days_in(r_month, r_leap);
    assign dim_prev   = days_in(r_month - 4'd1, r_leap);
    assign day_inc    = {1'b0, r_day} + 6'd1;
    assign fwd_roll   = day_inc > {1'b0, dim};
    assign fwd_ywrap  = fwd_roll && (r_month >= MONTH_DEC);
    assign back_roll  = r_day <= 5'd1;
    assign back_ywrap = back_roll && (r_month <= 4'd1);
    assign ychg_now   = (r_op == OP_BACK) ? back_ywrap : fwd_ywrap;
    assign steps_nz   = r_steps != '0;
    assign ld_bad     = (r_ld_day == '0) || (r_ld_month == '0) || (r_ld_month > MONTH_DEC);
    assign out_busy   = r_out_valid && !m_axis_tready;

    // year % 25 == 0 test, split over two steps around the multiplier
    assign q25_prod = {16'd0, r_year} * {16'd0, DIV25_RECIP};
    assign q25_x25  = {1'b0, r_q25, 4'd0} + {2'd0, r_q25, 3'd0} + {5'd0, r_q25};
    assign div25    = q25_x25 == {1'b0, r_year};

    assign s_axis_tready = uw.act == A_ACCEPT;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Sequencer: jump condition select
    always_comb begin
        unique case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !s_axis_tvalid;
            C_IS_LOAD:   take = r_op == OP_LOAD;
            C_STEP_CONT: take = steps_nz && !ychg_now;
            C_NO_YCHG:   take = !r_ychg;
            C_LD_BAD:    take = ld_bad;
            C_OUT_BUSY:  take = out_busy;
            default:     take = 1'b0;
        endcase
        n_upc = take ? uw.target : r_upc + 4'd1;
    end

    // Datapath driven by the control word
    always_comb begin
        n_op        = r_op;
        n_steps     = r_steps;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_leap      = r_leap;
        n_q25       = r_q25;
        n_ychg      = r_ychg;
        n_rej       = r_rej;
        n_ld_day    = r_ld_day;
        n_ld_month  = r_ld_month;
        n_ld_year   = r_ld_year;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        unique case (uw.act)
            A_NONE: begin
            end
            A_ACCEPT: begin
                if (s_axis_tvalid) begin
                    n_op       = in_op;
                    n_rej      = 1'b0;
                    n_ld_day   = s_axis_tdata[22:18];
                    n_ld_month = s_axis_tdata[26:23];
                    n_ld_year  = s_axis_tdata[42:27];
                    if (in_op == OP_FWD || in_op == OP_BACK) begin
                        n_steps = s_axis_tdata[2 +: CntW];
                    end else begin
                        n_steps = '0;
                    end
                end
            end
            A_STEP: begin
                n_ychg = steps_nz && ychg_now;
                if (steps_nz) begin
                    n_steps = r_steps - 1'b1;
                    if (r_op == OP_BACK) begin
                        if (back_ywrap) begin
                            n_month = MONTH_DEC;
                            n_year  = r_year - 16'd1;
                            n_day   = DAYS_DEC;
                        end else if (back_roll) begin
                            n_month = r_month - 4'd1;
                            n_day   = dim_prev;
                        end else begin
                            n_day = r_day - 5'd1;
                        end
                    end else begin
                        if (fwd_roll) begin
                            n_day = 5'd1;
                            if (fwd_ywrap) begin
                                n_month = 4'd1;
                                n_year  = r_year + 16'd1;
                            end else begin
                                n_month = r_month + 4'd1;
                            end
                        end else begin
                            n_day = day_inc[DAY_W-1:0];
                        end
                    end
                end
            end
            A_LEAP_MUL: begin
                n_q25 = q25_prod[DIV25_SHIFT +: Q25_W];
            end
            A_LEAP_SET: begin
                // div by 400 <=> div by 16 and 25; otherwise div by 4 and not 25
                n_leap = div25 ? (r_year[3:0] == 4'd0) : (r_year[1:0] == 2'd0);
                n_ychg = 1'b0;
            end
            A_CHECK: begin
                n_rej = ld_bad;
            end
            A_LOAD: begin
                n_day   = r_ld_day;
                n_month = r_ld_month;
                n_year  = r_ld_year;
            end
            A_EMIT: begin
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_rej, r_year, r_month, r_day};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= P_IDLE;
            r_op        <= OP_FWD;
            r_steps     <= '0;
            r_day       <= RST_DAY;
            r_month     <= RST_MONTH;
            r_year      <= RST_YEAR;
            r_leap      <= RST_LEAP;
            r_ychg      <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_op        <= n_op;
            r_steps     <= n_steps;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_leap      <= n_leap;
            r_ychg      <= n_ychg;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q25      <= n_q25;
        r_ld_day   <= n_ld_day;
        r_ld_month <= n_ld_month;
        r_ld_year  <= n_ld_year;
        r_out_data <= n_out_data;
    end

endmodule

// ===== hdl/gds_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gds_checker
// Port-level checks for the day stepper, bound to the top level.
// ---------------------------------------------------------------------------
module gds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // no result left pending out of reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // reported day always nonzero and month always within 1 to 12
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[8:5] != 4'd0)
                          && (m_axis_tdata[8:5] <= 4'd12))
        else $error("result date out of range");

    // fill bits stay clear
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:26] == 6'd0))
        else $error("result fill bits set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind gregorian_day_stepper_top gds_checker u_gds_checker (.*);
